>>> hw/rtl/bmpdec_pkg.sv
// Shared types and constants of the BMP stream pixel decoder.
// Used by the front parser, the event queue, the result formatter and the checker.
`timescale 1ns / 1ps

package bmpdec_pkg;

    // Size limits, default values of the top-level parameters
    localparam int unsigned DEF_MAX_WIDTH  = 4096;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;

    // Depth of the event queue between parser and formatter (power of two)
    localparam int unsigned Q_DEPTH = 4;

    // File and info header layout
    localparam int unsigned HDR_LEN      = 14 + 40;
    localparam int unsigned OFS_DATA_OFF = 10;
    localparam int unsigned OFS_DIB      = 14;
    localparam int unsigned OFS_WIDTH    = 18;
    localparam int unsigned OFS_HEIGHT   = 22;
    localparam int unsigned OFS_DEPTH    = 28;
    localparam int unsigned OFS_COMP     = 30;

    localparam logic [7:0]  SIG_B          = 8'h42;
    localparam logic [7:0]  SIG_M          = 8'h4D;
    localparam logic [31:0] DIB_MIN        = 32'd40;
    localparam logic [15:0] DEPTH_24       = 16'd24;
    localparam logic [15:0] DEPTH_16       = 16'd16;
    localparam logic [31:0] COMP_RGB       = 32'd0;
    localparam logic [31:0] COMP_BITFIELDS = 32'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HEADER,
        KIND_ERROR,
        KIND_STATUS
    } kind_t;

    typedef enum logic [3:0] {
        ERR_OK,
        ERR_SHORT_HDR,
        ERR_SIGNATURE,
        ERR_DIB_SIZE,
        ERR_DEPTH,
        ERR_COMPRESSION,
        ERR_WIDTH,
        ERR_HEIGHT,
        ERR_SHORT_PIX,
        ERR_LIMITS
    } err_t;

    // One parsed input byte: an optional main result plus an optional status
    typedef struct packed {
        logic        has_main;
        kind_t       kind;
        err_t        code;
        logic        is16;
        logic [7:0]  lo;
        logic [7:0]  mid;
        logic [7:0]  hi;
        logic [11:0] col;
        logic [11:0] row;
        logic [12:0] width;
        logic [12:0] height;
        logic        has_eof;
        err_t        eof_code;
    } evt_t;

endpackage

>>> hw/rtl/bmpdec_front.sv
// Front end of the BMP decoder: header parse and check, data skip, row walk.
// Emits one classified event per byte that yields results; uses bmpdec_pkg.
`timescale 1ns / 1ps

module bmpdec_front #(
    parameter int unsigned MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_file,
    output logic              evt_write,
    output bmpdec_pkg::evt_t  evt
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned BIR_W = $clog2(3 * MAX_WIDTH + 4);

    // Control state
    bmpdec_pkg::phase_t phase_reg, phase_next;
    logic [31:0]        pos_reg, pos_next;
    logic               sig_bad_reg, sig_bad_next;
    bmpdec_pkg::err_t   err_reg, err_next;
    logic               top_down_reg, top_down_next;
    logic               is16_reg, is16_next;
    logic [ROW_W-1:0]   abs_h_reg, abs_h_next;
    logic [BIR_W-1:0]   data_bytes_reg, data_bytes_next;
    logic [BIR_W-1:0]   row_bytes_reg, row_bytes_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BIR_W-1:0]   bir_reg, bir_next;
    logic [1:0]         k_reg, k_next;

    // Header words and held pixel bytes
    logic [31:0] off_reg, dib_reg, wid_reg, hgt_reg, comp_reg;
    logic [15:0] dep_reg;
    logic [7:0]  hold0_reg, hold1_reg;

    logic [5:0]       hdr_idx;
    logic [1:0]       lane;
    logic [31:0]      abs_h32;
    bmpdec_pkg::err_t hdr_err;
    logic [BIR_W-1:0] wid_b;
    logic [BIR_W-1:0] data_calc;
    logic [BIR_W-1:0] row_calc;
    logic             in_data;
    logic             pixel_done;
    logic [ROW_W-1:0] drow;
    logic [BIR_W-1:0] bir_inc;
    logic [ROW_W-1:0] row_inc;

    // Header byte index; the 32-bit words start two bytes past a 4-byte boundary
    assign hdr_idx = pos_reg[5:0];
    assign lane    = hdr_idx[1:0] + 2'd2;

    // Gather header fields, little endian
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == bmpdec_pkg::PH_HEADER)
        begin
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_DATA_OFF) && hdr_idx < 6'(bmpdec_pkg::OFS_DIB))
                off_reg[{lane, 3'b000} +: 8] <= data_byte;
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_DIB) && hdr_idx < 6'(bmpdec_pkg::OFS_WIDTH))
                dib_reg[{lane, 3'b000} +: 8] <= data_byte;
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_WIDTH) && hdr_idx < 6'(bmpdec_pkg::OFS_HEIGHT))
                wid_reg[{lane, 3'b000} +: 8] <= data_byte;
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_HEIGHT) && hdr_idx < 6'(bmpdec_pkg::OFS_HEIGHT + 4))
                hgt_reg[{lane, 3'b000} +: 8] <= data_byte;
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_DEPTH) && hdr_idx < 6'(bmpdec_pkg::OFS_COMP))
                dep_reg[{hdr_idx[0], 3'b000} +: 8] <= data_byte;
            if (hdr_idx >= 6'(bmpdec_pkg::OFS_COMP) && hdr_idx < 6'(bmpdec_pkg::OFS_COMP + 4))
                comp_reg[{lane, 3'b000} +: 8] <= data_byte;
        end
    end

    // Hold the leading bytes of a pixel
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == bmpdec_pkg::PH_PIXELS && in_data && !pixel_done)
        begin
            if (k_reg[0])
                hold1_reg <= data_byte;
            else
                hold0_reg <= data_byte;
        end
    end

    // Check the completed header
    assign abs_h32 = hgt_reg[31] ? (32'd0 - hgt_reg) : hgt_reg;

    always_comb
    begin
        if (sig_bad_reg)
            hdr_err = bmpdec_pkg::ERR_SIGNATURE;
        else if (dib_reg < bmpdec_pkg::DIB_MIN)
            hdr_err = bmpdec_pkg::ERR_DIB_SIZE;
        else if (dep_reg != bmpdec_pkg::DEPTH_24 && dep_reg != bmpdec_pkg::DEPTH_16)
            hdr_err = bmpdec_pkg::ERR_DEPTH;
        else if (dep_reg == bmpdec_pkg::DEPTH_24 && comp_reg != bmpdec_pkg::COMP_RGB)
            hdr_err = bmpdec_pkg::ERR_COMPRESSION;
        else if (dep_reg == bmpdec_pkg::DEPTH_16 && comp_reg != bmpdec_pkg::COMP_RGB
                 && comp_reg != bmpdec_pkg::COMP_BITFIELDS)
            hdr_err = bmpdec_pkg::ERR_COMPRESSION;
        else if (wid_reg == 32'd0 || wid_reg[31])
            hdr_err = bmpdec_pkg::ERR_WIDTH;
        else if (hgt_reg == 32'd0 || hgt_reg == 32'h8000_0000)
            hdr_err = bmpdec_pkg::ERR_HEIGHT;
        else if (wid_reg > 32'(MAX_WIDTH) || abs_h32 > 32'(MAX_HEIGHT)
                 || off_reg < 32'(bmpdec_pkg::HDR_LEN))
            hdr_err = bmpdec_pkg::ERR_LIMITS;
        else
            hdr_err = bmpdec_pkg::ERR_OK;
    end

    // Row geometry, taken when the header is accepted
    assign wid_b     = BIR_W'(wid_reg[COL_W-1:0]);
    assign data_calc = (dep_reg == bmpdec_pkg::DEPTH_16) ? (wid_b << 1) : ((wid_b << 1) + wid_b);
    assign row_calc  = (data_calc + BIR_W'(3)) & ~BIR_W'(3);

    // Pixel walk helpers
    assign in_data    = bir_reg < data_bytes_reg;
    assign pixel_done = in_data && (k_reg == (is16_reg ? 2'd1 : 2'd2));
    assign drow       = top_down_reg ? row_reg : (abs_h_reg - ROW_W'(1) - row_reg);
    assign bir_inc    = bir_reg + BIR_W'(1);
    assign row_inc    = row_reg + ROW_W'(1);

    // Next state and event
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        sig_bad_next    = sig_bad_reg;
        err_next        = err_reg;
        top_down_next   = top_down_reg;
        is16_next       = is16_reg;
        abs_h_next      = abs_h_reg;
        data_bytes_next = data_bytes_reg;
        row_bytes_next  = row_bytes_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        bir_next        = bir_reg;
        k_next          = k_reg;
        evt             = '0;

        if (accept)
        begin
            case (phase_reg)
                bmpdec_pkg::PH_HEADER:
                begin
                    if (pos_reg == 32'd0 && data_byte != bmpdec_pkg::SIG_B)
                        sig_bad_next = 1'b1;
                    if (pos_reg == 32'd1 && data_byte != bmpdec_pkg::SIG_M)
                        sig_bad_next = 1'b1;
                    if (pos_reg == 32'(bmpdec_pkg::HDR_LEN - 1))
                    begin
                        evt.has_main = 1'b1;
                        if (hdr_err != bmpdec_pkg::ERR_OK)
                        begin
                            err_next   = hdr_err;
                            phase_next = bmpdec_pkg::PH_DROP;
                            evt.kind   = bmpdec_pkg::KIND_ERROR;
                            evt.code   = hdr_err;
                        end
                        else
                        begin
                            err_next        = bmpdec_pkg::ERR_OK;
                            top_down_next   = hgt_reg[31];
                            is16_next       = (dep_reg == bmpdec_pkg::DEPTH_16);
                            abs_h_next      = abs_h32[ROW_W-1:0];
                            data_bytes_next = data_calc;
                            row_bytes_next  = row_calc;
                            phase_next      = (off_reg <= 32'(bmpdec_pkg::HDR_LEN)) ?
                                              bmpdec_pkg::PH_PIXELS : bmpdec_pkg::PH_SKIP;
                            evt.kind        = bmpdec_pkg::KIND_HEADER;
                            evt.code        = bmpdec_pkg::ERR_OK;
                            evt.width       = wid_reg[12:0];
                            evt.height      = abs_h32[12:0];
                        end
                    end
                end

                bmpdec_pkg::PH_SKIP:
                begin
                    if (({1'b0, pos_reg} + 33'd1) >= {1'b0, off_reg})
                        phase_next = bmpdec_pkg::PH_PIXELS;
                end

                bmpdec_pkg::PH_PIXELS:
                begin
                    if (in_data)
                    begin
                        if (pixel_done)
                        begin
                            evt.has_main = 1'b1;
                            evt.kind     = bmpdec_pkg::KIND_PIXEL;
                            evt.code     = bmpdec_pkg::ERR_OK;
                            evt.is16     = is16_reg;
                            evt.lo       = hold0_reg;
                            evt.mid      = hold1_reg;
                            evt.hi       = data_byte;
                            evt.col      = 12'(col_reg);
                            evt.row      = 12'(drow);
                            col_next     = col_reg + COL_W'(1);
                            k_next       = 2'd0;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    // Advance the row once its padded length is consumed
                    if (bir_inc >= row_bytes_reg)
                    begin
                        bir_next = '0;
                        col_next = '0;
                        k_next   = 2'd0;
                        row_next = row_inc;
                        if (row_inc >= abs_h_reg)
                            phase_next = bmpdec_pkg::PH_DONE;
                    end
                    else
                    begin
                        bir_next = bir_inc;
                    end
                end

                default:
                begin
                end
            endcase

            if (pos_reg != 32'hFFFF_FFFF)
                pos_next = pos_reg + 32'd1;

            // Close the file: report status and return to the reset state
            if (end_of_file)
            begin
                evt.has_eof = 1'b1;
                case (phase_next)
                    bmpdec_pkg::PH_HEADER: evt.eof_code = bmpdec_pkg::ERR_SHORT_HDR;
                    bmpdec_pkg::PH_DROP:   evt.eof_code = err_next;
                    bmpdec_pkg::PH_DONE:   evt.eof_code = bmpdec_pkg::ERR_OK;
                    default:               evt.eof_code = bmpdec_pkg::ERR_SHORT_PIX;
                endcase
                phase_next      = bmpdec_pkg::PH_HEADER;
                pos_next        = '0;
                sig_bad_next    = 1'b0;
                err_next        = bmpdec_pkg::ERR_OK;
                top_down_next   = 1'b0;
                is16_next       = 1'b0;
                abs_h_next      = '0;
                data_bytes_next = '0;
                row_bytes_next  = '0;
                col_next        = '0;
                row_next        = '0;
                bir_next        = '0;
                k_next          = 2'd0;
            end
        end
    end

    assign evt_write = accept && (evt.has_main || evt.has_eof);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bmpdec_pkg::PH_HEADER;
            pos_reg        <= '0;
            sig_bad_reg    <= 1'b0;
            err_reg        <= bmpdec_pkg::ERR_OK;
            top_down_reg   <= 1'b0;
            is16_reg       <= 1'b0;
            abs_h_reg      <= '0;
            data_bytes_reg <= '0;
            row_bytes_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            bir_reg        <= '0;
            k_reg          <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            sig_bad_reg    <= sig_bad_next;
            err_reg        <= err_next;
            top_down_reg   <= top_down_next;
            is16_reg       <= is16_next;
            abs_h_reg      <= abs_h_next;
            data_bytes_reg <= data_bytes_next;
            row_bytes_reg  <= row_bytes_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bir_reg        <= bir_next;
            k_reg          <= k_next;
        end
    end

endmodule

>>> hw/rtl/bmpdec_queue.sv
// Short event queue between the parser and the result formatter.
// Holds bmpdec_pkg::evt_t words; depth from bmpdec_pkg::Q_DEPTH.
`timescale 1ns / 1ps

module bmpdec_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmpdec_pkg::evt_t  push_evt,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bmpdec_pkg::evt_t  head_evt
);

    localparam int unsigned PTR_W = $clog2(bmpdec_pkg::Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(bmpdec_pkg::Q_DEPTH + 1);

    bmpdec_pkg::evt_t   slot_reg [bmpdec_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(bmpdec_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_evt   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    // Store a word
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_evt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/bmpdec_back.sv
// Back end of the BMP decoder: splits events into results, expands pixels to RGB888.
// Drives the registered result port; uses bmpdec_pkg.
`timescale 1ns / 1ps

module bmpdec_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  bmpdec_pkg::evt_t  head_evt,
    output logic              head_pop,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        result_kind,
    output logic [3:0]        error_code,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [11:0]       pixel_col,
    output logic [11:0]       pixel_row,
    output logic [12:0]       image_width,
    output logic [12:0]       image_height,
    output logic              last_of_file
);

    logic        out_valid_reg, out_valid_next;
    logic        second_reg, second_next;
    logic [1:0]  kind_reg;
    logic [3:0]  code_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [11:0] col_reg, row_reg;
    logic [12:0] width_reg, height_reg;
    logic        last_reg;

    logic        taken;
    logic        load;
    logic        use_eof;
    logic [7:0]  r_px, g_px, b_px;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;

    assign taken    = pop && out_valid_reg;
    assign load     = head_valid && (!out_valid_reg || taken);
    assign use_eof  = !head_evt.has_main || second_reg;
    assign head_pop = load && (use_eof || !head_evt.has_eof);

    // Swap BGR, or expand RGB565 by copying the top bits into the low bits
    assign r5 = head_evt.hi[7:3];
    assign g6 = {head_evt.hi[2:0], head_evt.lo[7:5]};
    assign b5 = head_evt.lo[4:0];

    always_comb
    begin
        if (head_evt.is16)
        begin
            r_px = {r5, r5[4:2]};
            g_px = {g6, g6[5:4]};
            b_px = {b5, b5[4:2]};
        end
        else
        begin
            r_px = head_evt.hi;
            g_px = head_evt.mid;
            b_px = head_evt.lo;
        end
    end

    // Output valid and split flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            second_next    = !use_eof && head_evt.has_eof;
        end
        else if (taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (use_eof)
            begin
                kind_reg   <= bmpdec_pkg::KIND_STATUS;
                code_reg   <= head_evt.eof_code;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
                width_reg  <= '0;
                height_reg <= '0;
                last_reg   <= 1'b1;
            end
            else
            begin
                kind_reg   <= head_evt.kind;
                code_reg   <= head_evt.code;
                col_reg    <= head_evt.col;
                row_reg    <= head_evt.row;
                width_reg  <= head_evt.width;
                height_reg <= head_evt.height;
                last_reg   <= 1'b0;
                if (head_evt.kind == bmpdec_pkg::KIND_PIXEL)
                begin
                    red_reg   <= r_px;
                    green_reg <= g_px;
                    blue_reg  <= b_px;
                end
                else
                begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= '0;
                end
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign result_kind  = kind_reg;
    assign error_code   = code_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign pixel_col    = col_reg;
    assign pixel_row    = row_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign last_of_file = last_reg;

endmodule

>>> hw/rtl/bmp_stream_pixel_decoder_top.sv
// BMP stream decoder top: takes one file byte per cycle while full is low and
// returns header, pixel, error and status results, each passing the event queue
// and the result register. Throughput: 1 byte per cycle while full is low; a
// final byte that also completes a pixel or the header gives two results.
// Reset: asynchronous, clears parser, queue and output; each file end rearms it.
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder_top #(
    parameter int unsigned MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [3:0]  error_code,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [11:0] pixel_col,
    output logic [11:0] pixel_row,
    output logic [12:0] image_width,
    output logic [12:0] image_height,
    output logic        last_of_file
);

    logic             accept;
    logic             evt_write;
    bmpdec_pkg::evt_t evt;
    logic             head_valid;
    logic             head_pop;
    bmpdec_pkg::evt_t head_evt;

    assign accept = push && !full;

    // Parse the byte stream
    bmpdec_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .evt_write   (evt_write),
        .evt         (evt)
    );

    // Buffer events
    bmpdec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (evt_write),
        .push_evt   (evt),
        .full       (full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_evt   (head_evt)
    );

    // Format results
    bmpdec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_evt     (head_evt),
        .head_pop     (head_pop),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .error_code   (error_code),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .image_width  (image_width),
        .image_height (image_height),
        .last_of_file (last_of_file)
    );

endmodule

>>> hw/rtl/bmpdec_checker.sv
// Port-level checks for the BMP stream decoder, bound to the top level.
// Depends on bmpdec_pkg for result kinds and error codes.
`timescale 1ns / 1ps

module bmpdec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  result_kind,
    input logic [3:0]  error_code,
    input logic [11:0] pixel_col,
    input logic [12:0] image_width,
    input logic [12:0] image_height,
    input logic        last_of_file
);

    // End flag only on status results
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_file) |-> (result_kind == bmpdec_pkg::KIND_STATUS))
        else $error("last_of_file on a result that is not a status");

    // Every status result closes the file
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == bmpdec_pkg::KIND_STATUS) |-> last_of_file)
        else $error("status result without last_of_file");

    // Pixels carry no error and no size
    a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == bmpdec_pkg::KIND_PIXEL) |->
        (error_code == bmpdec_pkg::ERR_OK && image_width == 13'd0 && image_height == 13'd0))
        else $error("pixel result with error or size fields set");

    // Accepted header has a nonzero size
    a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == bmpdec_pkg::KIND_HEADER) |->
        (error_code == bmpdec_pkg::ERR_OK && image_width != 13'd0 && image_height != 13'd0))
        else $error("header result with zero size or error");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(result_kind) && $stable(error_code) && $stable(pixel_col)))
        else $error("result changed while stalled");

endmodule

bind bmp_stream_pixel_decoder_top bmpdec_checker u_bmpdec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .error_code   (error_code),
    .pixel_col    (pixel_col),
    .image_width  (image_width),
    .image_height (image_height),
    .last_of_file (last_of_file)
);

>>> tb/bmp_stream_pixel_decoder_checker.sv
// Checker for the BMP stream pixel decoder: watches the byte and result queues,
// predicts every result word and compares it. Depends on bmpdec_pkg.
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder_checker #(
    parameter int unsigned MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  result_kind,
    input  logic [3:0]  error_code,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    input  logic        last_of_file,
    output int          fail_count,
    output int          outstanding
);
    import bmpdec_pkg::*;

    typedef struct {
        kind_t       kind;
        err_t        code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] col;
        logic [11:0] row;
        logic [12:0] width;
        logic [12:0] height;
        logic        last;
    } result_word_t;

    result_word_t pending_words[$];
    int errors = 0;

    // Decoder state as seen from the byte stream
    phase_t      stage;
    logic [31:0] byte_count;
    logic [31:0] data_offset;
    logic [31:0] dib_size;
    logic [31:0] width_field;
    logic [31:0] height_field;
    logic [15:0] depth_field;
    logic [31:0] comp_field;
    logic        top_down;
    logic [31:0] col_idx;
    logic [31:0] row_idx;
    logic [31:0] row_byte_idx;
    logic [15:0] pixel_hold;
    err_t        sticky_err;

    task automatic clear_state();
        stage        = PH_HEADER;
        byte_count   = '0;
        data_offset  = '0;
        dib_size     = '0;
        width_field  = '0;
        height_field = '0;
        depth_field  = '0;
        comp_field   = '0;
        top_down     = 1'b0;
        col_idx      = '0;
        row_idx      = '0;
        row_byte_idx = '0;
        pixel_hold   = '0;
        sticky_err   = ERR_OK;
    endtask

    task automatic queue_word(input kind_t kind, input err_t code,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [11:0] col, input logic [11:0] row,
                              input logic [12:0] w, input logic [12:0] h, input logic last);
        result_word_t word;
        word.kind   = kind;
        word.code   = code;
        word.red    = r;
        word.green  = g;
        word.blue   = b;
        word.col    = col;
        word.row    = row;
        word.width  = w;
        word.height = h;
        word.last   = last;
        pending_words.push_back(word);
    endtask

    // Advance the decoder by one accepted byte and queue the words it causes
    task automatic decode_byte(input logic [7:0] din, input logic eof);
        logic [31:0] pos;
        logic [31:0] abs_h;
        logic [31:0] bpb;
        logic [31:0] data_bytes;
        logic [31:0] row_bytes;
        logic [31:0] k;
        logic [31:0] drow;
        logic [15:0] v16;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  bl;
        err_t        hdr_err;
        err_t        end_code;
        pos   = byte_count;
        abs_h = height_field[31] ? (32'd0 - height_field) : height_field;
        case (stage)
            PH_HEADER:
            begin
                if (pos == 0 && din != SIG_B)
                    sticky_err = ERR_SIGNATURE;
                if (pos == 1 && din != SIG_M)
                    sticky_err = ERR_SIGNATURE;
                if (pos >= OFS_DATA_OFF && pos < OFS_DATA_OFF + 4)
                    data_offset |= 32'(din) << (8 * (pos - OFS_DATA_OFF));
                if (pos >= OFS_DIB && pos < OFS_DIB + 4)
                    dib_size |= 32'(din) << (8 * (pos - OFS_DIB));
                if (pos >= OFS_WIDTH && pos < OFS_WIDTH + 4)
                    width_field |= 32'(din) << (8 * (pos - OFS_WIDTH));
                if (pos >= OFS_HEIGHT && pos < OFS_HEIGHT + 4)
                    height_field |= 32'(din) << (8 * (pos - OFS_HEIGHT));
                if (pos >= OFS_DEPTH && pos < OFS_DEPTH + 2)
                    depth_field |= 16'(din) << (8 * (pos - OFS_DEPTH));
                if (pos >= OFS_COMP && pos < OFS_COMP + 4)
                    comp_field |= 32'(din) << (8 * (pos - OFS_COMP));
                if (pos == HDR_LEN - 1)
                begin
                    abs_h = height_field[31] ? (32'd0 - height_field) : height_field;
                    // Header checks in priority order
                    if (sticky_err != ERR_OK)
                        hdr_err = ERR_SIGNATURE;
                    else if (dib_size < DIB_MIN)
                        hdr_err = ERR_DIB_SIZE;
                    else if (depth_field != DEPTH_24 && depth_field != DEPTH_16)
                        hdr_err = ERR_DEPTH;
                    else if (depth_field == DEPTH_24 && comp_field != COMP_RGB)
                        hdr_err = ERR_COMPRESSION;
                    else if (depth_field == DEPTH_16 && comp_field != COMP_BITFIELDS
                             && comp_field != COMP_RGB)
                        hdr_err = ERR_COMPRESSION;
                    else if (width_field == 0 || width_field[31])
                        hdr_err = ERR_WIDTH;
                    else if (height_field == 0 || height_field == 32'h8000_0000)
                        hdr_err = ERR_HEIGHT;
                    else if (width_field > MAX_WIDTH || abs_h > MAX_HEIGHT
                             || data_offset < HDR_LEN)
                        hdr_err = ERR_LIMITS;
                    else
                        hdr_err = ERR_OK;
                    if (hdr_err != ERR_OK)
                    begin
                        sticky_err = hdr_err;
                        stage      = PH_DROP;
                        queue_word(KIND_ERROR, hdr_err, 0, 0, 0, 0, 0, 0, 0, 1'b0);
                    end
                    else
                    begin
                        sticky_err = ERR_OK;
                        top_down   = height_field[31];
                        stage      = (data_offset <= HDR_LEN) ? PH_PIXELS : PH_SKIP;
                        queue_word(KIND_HEADER, ERR_OK, 0, 0, 0, 0, 0,
                                   width_field[12:0], abs_h[12:0], 1'b0);
                    end
                end
            end
            PH_SKIP:
            begin
                if (pos + 32'd1 >= data_offset)
                    stage = PH_PIXELS;
            end
            PH_PIXELS:
            begin
                bpb        = 32'(depth_field / 8);
                data_bytes = width_field * bpb;
                row_bytes  = (data_bytes + 32'd3) & ~32'd3;
                if (row_byte_idx < data_bytes)
                begin
                    k = row_byte_idx - col_idx * bpb;
                    if (k + 32'd1 < bpb)
                    begin
                        pixel_hold |= 16'(din) << (k[0] ? 8 : 0);
                    end
                    else
                    begin
                        // BGR order for 24 bpp, RGB565 widened by bit replication
                        if (bpb == 32'd3)
                        begin
                            bl = pixel_hold[7:0];
                            g  = pixel_hold[15:8];
                            r  = din;
                        end
                        else
                        begin
                            v16 = {din, pixel_hold[7:0]};
                            r   = {v16[15:11], v16[15:13]};
                            g   = {v16[10:5], v16[10:9]};
                            bl  = {v16[4:0], v16[4:2]};
                        end
                        drow = top_down ? row_idx : (abs_h - 32'd1 - row_idx);
                        queue_word(KIND_PIXEL, ERR_OK, r, g, bl, col_idx[11:0], drow[11:0],
                                   0, 0, 1'b0);
                        col_idx++;
                        pixel_hold = '0;
                    end
                end
                // Drop row padding and move to the next row
                row_byte_idx++;
                if (row_byte_idx >= row_bytes)
                begin
                    row_byte_idx = '0;
                    col_idx      = '0;
                    pixel_hold   = '0;
                    row_idx++;
                    if (row_idx >= abs_h)
                        stage = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (byte_count != 32'hFFFF_FFFF)
            byte_count++;

        if (eof)
        begin
            case (stage)
                PH_HEADER: end_code = ERR_SHORT_HDR;
                PH_DROP:   end_code = sticky_err;
                PH_DONE:   end_code = ERR_OK;
                default:   end_code = ERR_SHORT_PIX;
            endcase
            queue_word(KIND_STATUS, end_code, 0, 0, 0, 0, 0, 0, 0, 1'b1);
            clear_state();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Predict on accepted bytes, compare on accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            clear_state();
            pending_words.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (push && !full)
                decode_byte(data_byte, end_of_file);
            if (pop && !empty)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: result word with none pending: expected nothing, actual kind %0d",
                             $time, result_kind);
                    errors++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    compare_field("result_kind", 32'(want.kind), 32'(result_kind));
                    compare_field("error_code", 32'(want.code), 32'(error_code));
                    compare_field("red", 32'(want.red), 32'(red));
                    compare_field("green", 32'(want.green), 32'(green));
                    compare_field("blue", 32'(want.blue), 32'(blue));
                    compare_field("pixel_col", 32'(want.col), 32'(pixel_col));
                    compare_field("pixel_row", 32'(want.row), 32'(pixel_row));
                    compare_field("image_width", 32'(want.width), 32'(image_width));
                    compare_field("image_height", 32'(want.height), 32'(image_height));
                    compare_field("last_of_file", 32'(want.last), 32'(last_of_file));
                end
            end
            outstanding <= pending_words.size();
            fail_count  <= errors;
        end
    end

endmodule

>>> tb/bmp_stream_pixel_decoder_top_tb.sv
// Testbench top for the BMP stream pixel decoder: builds BMP files byte by byte,
// streams them with random idling and gives the verdict. Depends on bmpdec_pkg,
// the decoder top and bmp_stream_pixel_decoder_checker.
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder_top_tb;
    import bmpdec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_file = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  result_kind;
    logic [3:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_of_file;
    int          fail_count;
    int          outstanding;

    int unsigned cycles = 0;
    bit          calm = 1'b0;
    int          random_bytes = 0;
    logic [7:0]  file_q[$];

    bmp_stream_pixel_decoder_top dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .data_byte(data_byte), .end_of_file(end_of_file),
        .empty(empty), .pop(pop), .result_kind(result_kind), .error_code(error_code),
        .red(red), .green(green), .blue(blue), .pixel_col(pixel_col), .pixel_row(pixel_row),
        .image_width(image_width), .image_height(image_height), .last_of_file(last_of_file)
    );

    bmp_stream_pixel_decoder_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .data_byte(data_byte), .end_of_file(end_of_file),
        .empty(empty), .pop(pop), .result_kind(result_kind), .error_code(error_code),
        .red(red), .green(green), .blue(blue), .pixel_col(pixel_col), .pixel_row(pixel_row),
        .image_width(image_width), .image_height(image_height), .last_of_file(last_of_file),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hold the run to a cycle budget
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: drop pop now and then unless in a calm stretch
    always @(posedge clk)
    begin
        pop <= (!calm && $urandom_range(99) < 9) ? 1'b0 : 1'b1;
    end

    // Pixel data bytes of one image, padding included
    function automatic int pixel_bytes(input logic [31:0] w, input logic [31:0] h,
                                       input logic [15:0] depth);
        logic [31:0] abs_h;
        logic [31:0] row;
        abs_h = h[31] ? (32'd0 - h) : h;
        row   = (w * 32'(depth / 8) + 32'd3) & ~32'd3;
        return int'(row * abs_h);
    endfunction

    // Fill file_q with a 54-byte header and body_len random bytes
    task automatic build_file(input logic [7:0] sig0, input logic [7:0] sig1,
                              input logic [31:0] offset, input logic [31:0] dib,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [15:0] depth, input logic [31:0] comp,
                              input int body_len);
        file_q.delete();
        repeat (HDR_LEN) file_q.push_back(8'($urandom));
        file_q[0] = sig0;
        file_q[1] = sig1;
        for (int i = 0; i < 4; i++)
        begin
            file_q[OFS_DATA_OFF + i] = offset[8*i +: 8];
            file_q[OFS_DIB + i]      = dib[8*i +: 8];
            file_q[OFS_WIDTH + i]    = w[8*i +: 8];
            file_q[OFS_HEIGHT + i]   = h[8*i +: 8];
            file_q[OFS_COMP + i]     = comp[8*i +: 8];
        end
        file_q[OFS_DEPTH]     = depth[7:0];
        file_q[OFS_DEPTH + 1] = depth[15:8];
        repeat (body_len) file_q.push_back(8'($urandom));
    endtask

    // Valid header; the body is the gap, the pixels and extra bytes (negative cuts)
    task automatic good_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] depth, input logic [31:0] comp,
                             input logic [31:0] offset, input int extra);
        int body;
        body = ((offset > HDR_LEN) ? int'(offset - HDR_LEN) : 0)
               + pixel_bytes(w, h, depth) + extra;
        if (body < 0)
            body = 0;
        build_file(SIG_B, SIG_M, offset, DIB_MIN, w, h, depth, comp, body);
    endtask

    task automatic trim(input int len);
        while (file_q.size() > len)
            void'(file_q.pop_back());
    endtask

    // Present one word and hold it until the decoder takes it
    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!calm && $urandom_range(99) < 9)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= value;
        end_of_file <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    // Hold off the sender until every predicted word has come back
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed small files, some with one broken field, some noise
    task automatic random_file();
        int unsigned pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offset;
        logic [31:0] dib;
        logic [31:0] comp;
        logic [15:0] depth;
        logic [7:0]  sig0;
        logic [7:0]  sig1;
        int          full_len;
        int          len;
        pick   = $urandom_range(99);
        depth  = $urandom_range(1) ? DEPTH_24 : DEPTH_16;
        comp   = (depth == DEPTH_16 && $urandom_range(1)) ? COMP_BITFIELDS : COMP_RGB;
        w      = $urandom_range(1, 6);
        h      = $urandom_range(1, 4);
        if ($urandom_range(1))
            h = 32'd0 - h;
        offset = ($urandom_range(3) == 0) ? HDR_LEN + $urandom_range(1, 8) : HDR_LEN;
        dib    = ($urandom_range(4) == 0) ? 32'($urandom_range(41, 200)) : DIB_MIN;
        sig0   = SIG_B;
        sig1   = SIG_M;
        full_len = int'(offset - HDR_LEN) + pixel_bytes(w, h, depth);
        len      = full_len;
        if (pick < 65)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(0, full_len - 1);
            else if ($urandom_range(9) == 0)
                len = full_len + $urandom_range(1, 6);
        end
        else if (pick < 88)
        begin
            len = $urandom_range(0, 12);
            case ($urandom_range(8))
                0: sig0 = SIG_B ^ (8'h01 << $urandom_range(7));
                1: sig1 = SIG_M ^ (8'h01 << $urandom_range(7));
                2: dib = $urandom_range(0, 39);
                3:
                begin
                    depth = 16'($urandom_range(0, 40));
                    if (depth == DEPTH_16 || depth == DEPTH_24)
                        depth = 16'd32;
                end
                4:
                begin
                    comp = $urandom_range(1) ? 32'($urandom_range(1, 2)) : ($urandom | 32'h4);
                    if (depth == DEPTH_24 && $urandom_range(2) == 0)
                        comp = COMP_BITFIELDS;
                end
                5: w = $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000);
                6: h = $urandom_range(1) ? 32'd0 : 32'h8000_0000;
                7:
                begin
                    w = $urandom_range(4097, 9000);
                    if ($urandom_range(1))
                    begin
                        w = 32'd1;
                        h = $urandom_range(4097, 9000);
                        if ($urandom_range(1))
                            h = 32'd0 - h;
                    end
                end
                default: offset = $urandom_range(0, 53);
            endcase
        end
        if (pick < 88)
        begin
            build_file(sig0, sig1, offset, dib, w, h, depth, comp, len);
        end
        else
        begin
            file_q.delete();
            len = $urandom_range(1, 70);
            repeat (len) file_q.push_back(8'($urandom));
            if (len > 1 && $urandom_range(1))
            begin
                file_q[0] = SIG_B;
                file_q[1] = SIG_M;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Well-formed files: padding, skip, both depths, both row orders
        good_file(3, 2, DEPTH_24, COMP_RGB, HDR_LEN, 0);
        send_file();
        good_file(2, -2, DEPTH_24, COMP_RGB, 60, 0);
        send_file();
        good_file(1, 3, DEPTH_16, COMP_RGB, HDR_LEN, 0);
        send_file();
        good_file(3, -1, DEPTH_16, COMP_BITFIELDS, HDR_LEN, 0);
        send_file();
        // Trailing bytes after the last row, cut in pixels, cut in the skip
        good_file(1, 1, DEPTH_24, COMP_RGB, HDR_LEN, 5);
        send_file();
        good_file(2, 2, DEPTH_24, COMP_RGB, HDR_LEN, -3);
        send_file();
        good_file(1, 1, DEPTH_24, COMP_RGB, 80, -25);
        send_file();
        // End on the last header byte, and on the last pixel of the image
        good_file(1, 1, DEPTH_24, COMP_RGB, HDR_LEN, -4);
        send_file();
        good_file(4, 1, DEPTH_24, COMP_RGB, HDR_LEN, 0);
        send_file();
        good_file(1, -4096, DEPTH_16, COMP_BITFIELDS, HDR_LEN, -16384);
        send_file();
        build_file(SIG_B, SIG_M, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, DEPTH_24, COMP_RGB, 10);
        send_file();
        // Short header, one-byte file, bad signature then short
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_24, COMP_RGB, 0);
        trim(20);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_24, COMP_RGB, 0);
        trim(1);
        send_file();
        build_file(8'h00, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_24, COMP_RGB, 0);
        trim(30);
        send_file();
        // Header errors, one check each, plus an order check
        build_file(8'h41, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_24, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, 8'h4E, HDR_LEN, 10, 1, 1, 16'd8, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, 39, 1, 1, 16'd8, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 1, 16'd32, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_24, COMP_BITFIELDS, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 1, DEPTH_16, 32'd1, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 0, 1, DEPTH_24, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 32'h8000_0000, 1, DEPTH_24, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 0, DEPTH_24, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, 32'h8000_0000, DEPTH_24, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 4097, 1, DEPTH_16, COMP_RGB, 8);
        send_file();
        build_file(SIG_B, SIG_M, HDR_LEN, DIB_MIN, 1, -4097, DEPTH_16, COMP_RGB, 0);
        send_file();
        build_file(SIG_B, SIG_M, 53, DIB_MIN, 1, 1, DEPTH_24, COMP_RGB, 8);
        send_file();
        // Largest accepted sizes, cut after the first few pixels
        good_file(4096, 1, DEPTH_24, COMP_RGB, HDR_LEN, -12264);
        send_file();
        good_file(1, 4096, DEPTH_16, COMP_RGB, HDR_LEN, -16360);
        send_file();
        wait_drained();

        // Random files, with a calm stretch in the middle
        while (random_bytes < RANDOM_BYTES)
        begin
            calm = (random_bytes >= 200 && random_bytes < 500);
            if ($urandom_range(5) == 0)
                wait_drained();
            random_file();
            send_file();
            random_bytes += file_q.size();
        end
        calm = 1'b0;

        wait_drained();
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
